[hw/rtl/pfx_pkg.sv]
// shared types, mode codes and helpers for the rgb24 pixel effect stream
package pfx_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// effect mode codes
	localparam logic [3:0] MODE_NONE      = 4'd0;
	localparam logic [3:0] MODE_RED       = 4'd1;
	localparam logic [3:0] MODE_GREEN     = 4'd2;
	localparam logic [3:0] MODE_BLUE      = 4'd3;
	localparam logic [3:0] MODE_DARKEN    = 4'd4;
	localparam logic [3:0] MODE_INVERT    = 4'd5;
	localparam logic [3:0] MODE_POSTERIZE = 4'd6;
	localparam logic [3:0] MODE_BLUR      = 4'd7;
	localparam logic [3:0] MODE_GREY      = 4'd8;
	localparam logic [3:0] MODE_EMBOSS    = 4'd9;

	localparam logic [3:0] MODE_RESET = MODE_RED;

	localparam logic [7:0] INVERT_MASK    = 8'hff;
	localparam logic [7:0] POSTERIZE_MASK = 8'he0;
	localparam logic [7:0] EMBOSS_MID     = 8'd128;

	// up to three results per transaction, emitted in order
	typedef struct packed {
		pixel_t [2:0] ent;
		logic [1:0]   n;
		logic         row_end;
	} res_list_t;

	function automatic logic [7:0] grey_of(input pixel_t p);
		logic [8:0] s;
		begin
			s = {1'b0, p.red} + {1'b0, p.green};
			grey_of = s[8:1];
		end
	endfunction

endpackage

[hw/rtl/pfx_effect.sv]
// pointwise effects: channel select, darken, invert, posterize, grey and emboss
module pfx_effect (
	input  logic [3:0]     mode,
	input  pfx_pkg::pixel_t pix,
	input  logic           mid_row,
	input  logic [7:0]     prev_grey,
	output pfx_pkg::pixel_t res
);

	logic [7:0] grey;
	logic signed [9:0] diff;
	logic [7:0] emb;

	assign grey = pfx_pkg::grey_of(pix);
	assign diff = $signed({2'b00, grey}) - $signed({2'b00, prev_grey});

	// clamp to -127..127 then bias by 128; the first pixel of a row gives 128
	always_comb begin
		if (!mid_row) begin
			emb = pfx_pkg::EMBOSS_MID;
		end else if (diff > 10'sd127) begin
			emb = 8'd255;
		end else if (diff < -10'sd127) begin
			emb = 8'd1;
		end else begin
			emb = diff[7:0] ^ pfx_pkg::EMBOSS_MID;
		end
	end

	always_comb begin
		case (mode)
			pfx_pkg::MODE_RED:       res = '{red: pix.red, green: 8'd0, blue: 8'd0};
			pfx_pkg::MODE_GREEN:     res = '{red: 8'd0, green: pix.green, blue: 8'd0};
			pfx_pkg::MODE_BLUE:      res = '{red: 8'd0, green: 8'd0, blue: pix.blue};
			pfx_pkg::MODE_DARKEN:    res = '{red: pix.red >> 1, green: pix.green >> 1,
				blue: pix.blue >> 1};
			pfx_pkg::MODE_INVERT:    res = '{red: pix.red ^ pfx_pkg::INVERT_MASK,
				green: pix.green ^ pfx_pkg::INVERT_MASK, blue: pix.blue ^ pfx_pkg::INVERT_MASK};
			pfx_pkg::MODE_POSTERIZE: res = '{red: pix.red & pfx_pkg::POSTERIZE_MASK,
				green: pix.green & pfx_pkg::POSTERIZE_MASK,
				blue: pix.blue & pfx_pkg::POSTERIZE_MASK};
			pfx_pkg::MODE_GREY:      res = '{red: grey, green: grey, blue: grey};
			pfx_pkg::MODE_EMBOSS:    res = '{red: emb, green: emb, blue: emb};
			default:                 res = pix;
		endcase
	end

endmodule

[hw/rtl/pfx_hold.sv]
// blur hold pixels and the per-transaction result list
module pfx_hold (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        mode,
	input  pfx_pkg::pixel_t   pix,
	input  logic              last,
	input  pfx_pkg::pixel_t   res,
	input  logic              adv,
	output pfx_pkg::res_list_t list
);

	pfx_pkg::pixel_t h0_q, h1_q;
	logic [1:0] cnt_q;
	logic blur;

	assign blur = (mode == pfx_pkg::MODE_BLUR);

	function automatic pfx_pkg::pixel_t avg(input pfx_pkg::pixel_t a, input pfx_pkg::pixel_t b);
		logic [8:0] sr, sg, sb;
		begin
			sr = {1'b0, a.red} + {1'b0, b.red};
			sg = {1'b0, a.green} + {1'b0, b.green};
			sb = {1'b0, a.blue} + {1'b0, b.blue};
			avg = '{red: sr[8:1], green: sg[8:1], blue: sb[8:1]};
		end
	endfunction

	always_comb begin
		list.ent     = {3{pix}};
		list.n       = 2'd0;
		list.row_end = last;
		if (blur) begin
			case (cnt_q)
				2'd2: begin
					list.ent[0] = avg(h0_q, pix);
					list.ent[1] = h1_q;
					list.ent[2] = pix;
					list.n      = last ? 2'd3 : 2'd1;
				end
				2'd1: begin
					list.ent[0] = h0_q;
					list.ent[1] = pix;
					list.n      = last ? 2'd2 : 2'd0;
				end
				default: begin
					list.ent[0] = pix;
					list.n      = last ? 2'd1 : 2'd0;
				end
			endcase
		end else begin
			// any held pixels drain unchanged ahead of this result
			case (cnt_q)
				2'd2: begin
					list.ent[0] = h0_q;
					list.ent[1] = h1_q;
					list.ent[2] = res;
					list.n      = 2'd3;
				end
				2'd1: begin
					list.ent[0] = h0_q;
					list.ent[1] = res;
					list.n      = 2'd2;
				end
				default: begin
					list.ent[0] = res;
					list.n      = 2'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			h0_q  <= '0;
			h1_q  <= '0;
		end else if (adv) begin
			if (!blur) begin
				cnt_q <= 2'd0;
			end else if (cnt_q == 2'd2) begin
				h0_q  <= h1_q;
				h1_q  <= pix;
				cnt_q <= last ? 2'd0 : 2'd2;
			end else begin
				if (cnt_q[0]) begin
					h1_q <= pix;
				end else begin
					h0_q <= pix;
				end
				cnt_q <= last ? 2'd0 : cnt_q + 2'd1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("hold count out of range");

	a_nonblur_drains: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !blur |=> cnt_q == 2'd0)
		else $error("hold not emptied outside blur");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last |=> cnt_q == 2'd0)
		else $error("hold not emptied at row end");

endmodule

[hw/rtl/rgb24_pixel_effect_stream.sv]
// top level of the rgb24 pixel effect stream
// One pixel enters per transaction into an input register; the selected effect is applied by
// short logic after that register and the result lands in an output register, so one pixel
// per clock flows through while the input is not stalled. Each pixel gives one result, except
// in blur, where the first two pixels of a row are held back (no result) and the row-end
// pixel flushes the held pixels and itself: up to three results, one per cycle while out_stall
// is low, with the input stalled during the extra cycles. Leaving blur with pixels held emits
// them unchanged ahead of the next pixel's result. run_last marks the final result of each
// input transaction and row_end_out the final pixel of a row. effect_mode resets to red only
// and may be written only while the block is idle; codes above nine act as pass-through.
module rgb24_pixel_effect_stream (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pix_red,
	input  logic [7:0] pix_green,
	input  logic [7:0] pix_blue,
	input  logic       row_last_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] res_red,
	output logic [7:0] res_green,
	output logic [7:0] res_blue,
	output logic       row_end_out,
	output logic       run_last
);

	logic [3:0] mode_q;
	logic [7:0] prev_grey_q;
	logic       mid_row_q;

	// input register
	logic            valid_s1;
	pfx_pkg::pixel_t pix_s1;
	logic            last_s1;

	// output register
	logic            out_valid_q;
	pfx_pkg::pixel_t res_q;
	logic            row_end_q;
	logic            run_last_q;

	logic [1:0]         idx_q;
	pfx_pkg::pixel_t    pt_res;
	pfx_pkg::res_list_t list;
	pfx_pkg::pixel_t    ent_sel;
	logic               slot_free;
	logic               emit;
	logic               final_ent;
	logic               retire;
	logic               in_take;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pfx_pkg::MODE_RESET;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	pfx_effect u_effect (
		.mode      (mode_q),
		.pix       (pix_s1),
		.mid_row   (mid_row_q),
		.prev_grey (prev_grey_q),
		.res       (pt_res)
	);

	pfx_hold u_hold (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode_q),
		.pix    (pix_s1),
		.last   (last_s1),
		.res    (pt_res),
		.adv    (retire),
		.list   (list)
	);

	// output slot frees when empty or being taken this cycle
	assign slot_free = !out_valid_q || !out_stall;
	assign final_ent = (idx_q == list.n - 2'd1);
	assign emit      = valid_s1 && (list.n != 2'd0) && slot_free;
	// item leaves s1 after its last result, or at once when it gives none
	assign retire    = valid_s1 && ((list.n == 2'd0) || (emit && final_ent));
	assign in_stall  = valid_s1 && !retire;
	assign in_take   = in_valid && !in_stall;

	always_comb begin
		case (idx_q)
			2'd1:    ent_sel = list.ent[1];
			2'd2:    ent_sel = list.ent[2];
			default: ent_sel = list.ent[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pix_s1  <= '{red: pix_red, green: pix_green, blue: pix_blue};
			last_s1 <= row_last_in;
		end
	end

	// per-pixel state advances when the item retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_grey_q <= 8'd0;
			mid_row_q   <= 1'b0;
		end else if (retire) begin
			prev_grey_q <= pfx_pkg::grey_of(pix_s1);
			mid_row_q   <= !last_s1;
		end
	end

	// result index within the current transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (retire) begin
			idx_q <= 2'd0;
		end else if (emit) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q      <= ent_sel;
			run_last_q <= final_ent;
			row_end_q  <= final_ent && list.row_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign res_red     = res_q.red;
	assign res_green   = res_q.green;
	assign res_blue    = res_q.blue;
	assign row_end_out = row_end_q;
	assign run_last    = run_last_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && list.n != 2'd0 |-> idx_q < list.n)
		else $error("result index past list length");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> idx_q == 2'd0)
		else $error("result index nonzero with no item");

	a_retire_idx: assert property (@(posedge clk) disable iff (!arst_n)
		retire |=> idx_q == 2'd0)
		else $error("result index not cleared after retire");

	a_row_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && row_end_q |-> run_last_q)
		else $error("row end on a result that is not the last of its transaction");

endmodule
